### hdl/pse_pkg.sv
// Shared types and constants for the postfix stack evaluator.
// Token, result and arithmetic request structs, action/status/op codes, sequencer and arithmetic unit states.
// No dependencies.
package pse_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int STACK_DEPTH_DEF = 64;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int ACTION_W        = 3;
  localparam int FIELD_W         = 32;
  localparam int DEPTH_OUT_W     = 7;

  typedef enum logic [2:0] {
    ACT_PUSH    = 3'd0,
    ACT_ADD     = 3'd1,
    ACT_SUB     = 3'd2,
    ACT_MUL     = 3'd3,
    ACT_DIV     = 3'd4,
    ACT_END     = 3'd5,
    ACT_UNKNOWN = 3'd6
  } action_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FEW     = 3'd1,
    ST_DIVZERO = 3'd2,
    ST_FULL    = 3'd3,
    ST_UNKNOWN = 3'd4,
    ST_EMPTY   = 3'd5,
    ST_ABORTED = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } alu_op_t;

  typedef enum logic [1:0] {
    U_IDLE = 2'd0,
    U_RUN  = 2'd1,
    U_FIN  = 2'd2
  } unit_state_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_DECODE = 3'd1,
    S_EXEC   = 3'd2,
    S_WAIT   = 3'd3,
    S_DONE   = 3'd4
  } seq_state_t;

  typedef struct packed {
    logic                       start;
    alu_op_t                    op;
  } alu_req_t;

  typedef struct packed {
    logic [ACTION_W-1:0]        action;
    logic signed [FIELD_W-1:0]  operand_value;
  } tok_t;

  typedef struct packed {
    logic [2:0]                 status;
    logic signed [FIELD_W-1:0]  top_value;
    logic [DEPTH_OUT_W-1:0]     stack_depth;
  } res_t;

endpackage

### hdl/postfix_stack_evaluator.sv
// Postfix expression evaluator: one token beat in, one result beat out.
// Top of stack in a register, lower entries in pse_stack_ram, math in pse_arith_unit.
// Depends on pse_pkg, pse_stack_ram, pse_arith_unit.
//
// Usage:
//   Token channel (tok_valid/tok_stall/tok) carries an action and a Q16.16 value.
//   Result channel (res_valid/res_stall/res) returns status, top value and depth,
//   one result beat for every token beat, in order.
//   tok_stall is high from the accepted token until its result is loaded into
//   the output register; one token is in work at a time.
// Flow: every token passes S_DECODE and S_DONE; add, subtract, multiply and divide
//   with no abort pending and two or more entries also pass S_EXEC, then S_WAIT
//   unless the divide is by zero. Multiply and divide run in the one-bit-per-cycle
//   shift-add and restoring loops of the arithmetic unit.
// Reset (rst, synchronous) empties the stack, clears the abort flag and drops
//   any pending result. Stack storage is not cleared.
// A stalled result holds in the output register; the next token is accepted
//   meanwhile and its result waits until the register frees.
module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = pse_pkg::VALUE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          tok_valid,
  output logic          tok_stall,
  input  pse_pkg::tok_t tok,
  output logic          res_valid,
  input  logic          res_stall,
  output pse_pkg::res_t res
);
  import pse_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  seq_state_t          state, state_next;
  logic [ACTION_W-1:0] act;
  logic [W-1:0]        val;
  logic [DW-1:0]       depth;
  logic                aborted;
  logic [W-1:0]        top_reg;
  status_t             st;
  logic                is_end;

  logic [DW-1:0]       dm1, dm2;
  logic                wr_en, rd_en;
  logic [W-1:0]        rd_data;
  alu_req_t            req;
  logic                done;
  logic [W-1:0]        result;
  logic                res_free;

  logic [W+FIELD_W-1:0]     in_ext;
  logic [W-1:0]             out_top;
  logic [FIELD_W+W-1:0]     out_ext;
  logic [DW-1:0]            out_depth;
  logic [DEPTH_OUT_W+DW-1:0] depth_ext;

  assign dm1 = depth - DW'(1);
  assign dm2 = depth - DW'(2);
  assign res_free = !res_valid || !res_stall;
  assign tok_stall = (state != S_IDLE);

  assign in_ext    = {{W{tok.operand_value[FIELD_W-1]}}, tok.operand_value};
  assign out_top   = is_end ? ((st == ST_OK) ? top_reg : '0)
                            : ((depth == '0) ? '0 : top_reg);
  assign out_ext   = {{FIELD_W{out_top[W-1]}}, out_top};
  assign out_depth = is_end ? '0 : depth;
  assign depth_ext = {{DEPTH_OUT_W{1'b0}}, out_depth};

  pse_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (dm1[AW-1:0]),
    .wr_data (top_reg),
    .rd_en   (rd_en),
    .rd_addr (dm2[AW-1:0]),
    .rd_data (rd_data)
  );

  pse_arith_unit #(
    .VALUE_WIDTH (W)
  ) u_arith (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .a      (rd_data),
    .b      (top_reg),
    .done   (done),
    .result (result)
  );

  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    req.start  = 1'b0;
    case (act)
      ACT_SUB: req.op = OP_SUB;
      ACT_MUL: req.op = OP_MUL;
      ACT_DIV: req.op = OP_DIV;
      default: req.op = OP_ADD;
    endcase
    case (state)
      S_IDLE: begin
        if (tok_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        if (act != ACT_END && !aborted) begin
          case (act)
            ACT_PUSH: begin
              wr_en = (depth != DW'(STACK_DEPTH)) && (depth != '0);
            end
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
              if (depth >= DW'(2)) begin
                rd_en      = 1'b1;
                state_next = S_EXEC;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_EXEC: begin
        if (act == ACT_DIV && top_reg == '0) begin
          state_next = S_DONE;
        end else begin
          req.start  = 1'b1;
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_DONE && res_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth   <= '0;
      aborted <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (tok_valid) begin
            act <= tok.action;
            val <= in_ext[W-1:0];
          end
        end
        S_DECODE: begin
          is_end <= (act == ACT_END);
          if (act == ACT_END) begin
            if (aborted) begin
              st <= ST_ABORTED;
            end else if (depth == '0) begin
              st <= ST_EMPTY;
            end else begin
              st <= ST_OK;
            end
          end else if (aborted) begin
            st <= ST_ABORTED;
          end else begin
            case (act)
              ACT_PUSH: begin
                if (depth == DW'(STACK_DEPTH)) begin
                  st      <= ST_FULL;
                  aborted <= 1'b1;
                end else begin
                  st      <= ST_OK;
                  top_reg <= val;
                  depth   <= depth + DW'(1);
                end
              end
              ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
                if (depth < DW'(2)) begin
                  st      <= ST_FEW;
                  aborted <= 1'b1;
                end else begin
                  st <= ST_OK;
                end
              end
              default: begin
                st <= ST_UNKNOWN;
              end
            endcase
          end
        end
        S_EXEC: begin
          if (act == ACT_DIV && top_reg == '0) begin
            st      <= ST_DIVZERO;
            aborted <= 1'b1;
          end
        end
        S_WAIT: begin
          if (done) begin
            top_reg <= result;
            depth   <= dm1;
          end
        end
        S_DONE: begin
          if (res_free) begin
            res.status      <= st;
            res.top_value   <= out_ext[FIELD_W-1:0];
            res.stack_depth <= depth_ext[DEPTH_OUT_W-1:0];
            if (is_end) begin
              depth   <= '0;
              aborted <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### hdl/pse_stack_ram.sv
// Operand storage below the top of stack: one write port, one registered read port.
// Depends on nothing but its parameters.
module pse_stack_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/pse_arith_unit.sv
// Shared arithmetic unit: one adder for saturating add/subtract, bit-serial
// shift-add multiply and restoring divide, with Q-format truncation and saturation.
// Depends on pse_pkg.
module pse_arith_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  pse_pkg::alu_req_t      req,
  input  logic [VALUE_WIDTH-1:0] a,
  input  logic [VALUE_WIDTH-1:0] b,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] result
);
  import pse_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int QW = W + FRAC_BITS;
  localparam int RW = 2 * W;
  localparam int CW = $clog2(QW + 1);

  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};

  unit_state_t   ustate;
  alu_op_t       opr;
  logic [W:0]    acc;
  logic [QW-1:0] mreg;
  logic [W-1:0]  dvs;
  logic          neg;
  logic [CW-1:0] cnt;

  logic [W-1:0]  a_mag, b_mag;
  logic [W:0]    add_x, add_y, sum;
  logic          add_sub;
  logic [W-1:0]  addsub_res;
  logic [RW-1:0] q;
  logic          hi_nz;
  logic [W-1:0]  q_lo;
  logic [W-1:0]  sat_res;

  assign a_mag = a[W-1] ? (~a + {{(W-1){1'b0}}, 1'b1}) : a;
  assign b_mag = b[W-1] ? (~b + {{(W-1){1'b0}}, 1'b1}) : b;

  always_comb begin
    add_x   = {a[W-1], a};
    add_y   = {b[W-1], b};
    add_sub = (req.op == OP_SUB);
    if (ustate != U_IDLE) begin
      if (opr == OP_MUL) begin
        add_x   = acc;
        add_y   = mreg[0] ? {1'b0, dvs} : '0;
        add_sub = 1'b0;
      end else begin
        add_x   = {acc[W-1:0], mreg[QW-1]};
        add_y   = {1'b0, dvs};
        add_sub = 1'b1;
      end
    end
  end

  assign sum = add_x + (add_y ^ {(W+1){add_sub}}) + {{W{1'b0}}, add_sub};

  assign addsub_res = (sum[W] != sum[W-1]) ? (sum[W] ? MINV : MAXV) : sum[W-1:0];

  always_comb begin
    q = '0;
    if (opr == OP_MUL) begin
      q = {acc[W-1:0], mreg[W-1:0]} >> FRAC_BITS;
    end else begin
      q[QW-1:0] = mreg;
    end
  end

  assign hi_nz = |q[RW-1:W];
  assign q_lo  = q[W-1:0];

  always_comb begin
    if (neg) begin
      sat_res = (hi_nz || (q_lo > MINV)) ? MINV : (~q_lo + {{(W-1){1'b0}}, 1'b1});
    end else begin
      sat_res = (hi_nz || q_lo[W-1]) ? MAXV : q_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ustate <= U_IDLE;
      done   <= 1'b0;
    end else begin
      done <= (ustate == U_FIN) ||
              ((ustate == U_IDLE) && req.start && ((req.op == OP_ADD) || (req.op == OP_SUB)));
      case (ustate)
        U_IDLE: begin
          if (req.start) begin
            opr <= req.op;
            neg <= a[W-1] ^ b[W-1];
            acc <= '0;
            case (req.op)
              OP_MUL: begin
                mreg   <= QW'(b_mag);
                dvs    <= a_mag;
                cnt    <= CW'(W);
                ustate <= U_RUN;
              end
              OP_DIV: begin
                mreg   <= {a_mag, {FRAC_BITS{1'b0}}};
                dvs    <= b_mag;
                cnt    <= CW'(QW);
                ustate <= U_RUN;
              end
              default: begin
                result <= addsub_res;
              end
            endcase
          end
        end
        U_RUN: begin
          if (opr == OP_MUL) begin
            {acc, mreg[W-1:0]} <= {sum, mreg[W-1:0]} >> 1;
          end else begin
            acc  <= sum[W] ? add_x : sum;
            mreg <= {mreg[QW-2:0], ~sum[W]};
          end
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            ustate <= U_FIN;
          end
        end
        U_FIN: begin
          result <= sat_res;
          ustate <= U_IDLE;
        end
        default: begin
          ustate <= U_IDLE;
        end
      endcase
    end
  end

endmodule

### test/tb_top.sv
// Self-checking bench for postfix_stack_evaluator: token beats in, result beats compared
// field by field against a Q16.16 stack evaluator kept in the bench.
// Depends on pse_pkg and the evaluator RTL.
`timescale 1ns / 100ps

module tb_top;
  import pse_pkg::*;

  localparam logic [2:0]  ACT_RESERVED = 3'd7;
  localparam int          STACK_N      = STACK_DEPTH_DEF;
  localparam logic [31:0] Q_MAX        = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN        = 32'h8000_0000;
  localparam logic [31:0] Q_ONE        = 32'h0001_0000;
  localparam longint      L_MAX        = 64'sd2147483647;
  localparam longint      L_MIN        = -64'sd2147483648;
  localparam int          LIMIT        = 400000;
  localparam int          DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic tok_valid = 1'b0;
  logic tok_stall;
  tok_t tok = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  tok_t pending_tokens[$];
  res_t expected_results[$];

  logic signed [31:0] opnd_mem [0:STACK_N-1];
  int   depth_q = 0;
  bit   aborted_q = 1'b0;

  bit   tok_beat_done = 1'b0;
  bit   res_beat_done = 1'b0;
  logic res_hold = 1'b0;
  int   tok_wait = 0;
  int   res_wait = 0;
  int   tok_mode = 0;
  int   res_mode = 1;
  int   tok_beats = 0;
  int   res_beats = 0;
  int   results_checked = 0;
  int   fail_count = 0;
  int   cycle_cnt = 0;
  int   status_seen [0:7];
  int   n_random = 0;

  postfix_stack_evaluator u_top (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok       (tok),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- evaluator
  function automatic logic [63:0] mag64(input logic signed [31:0] x);
    longint sx;
    sx = x;
    return (sx < 0) ? 64'(-sx) : 64'(sx);
  endfunction

  function automatic logic [31:0] sat_from_mag(input bit neg, input logic [63:0] m);
    logic [63:0] neg_m;
    neg_m = 64'd0 - m;
    if (neg) return (m > 64'h8000_0000) ? Q_MIN : neg_m[31:0];
    return (m > 64'h7FFF_FFFF) ? Q_MAX : m[31:0];
  endfunction

  function automatic logic [31:0] sat_sum(input longint s);
    if (s > L_MAX) return Q_MAX;
    if (s < L_MIN) return Q_MIN;
    return s[31:0];
  endfunction

  function automatic logic [31:0] apply_op(input logic [2:0] a,
                                           input logic signed [31:0] x,
                                           input logic signed [31:0] y);
    case (a)
      ACT_ADD: return sat_sum(longint'(x) + longint'(y));
      ACT_SUB: return sat_sum(longint'(x) - longint'(y));
      ACT_MUL: return sat_from_mag(x[31] ^ y[31], (mag64(x) * mag64(y)) >> FRAC_BITS);
      default: return sat_from_mag(x[31] ^ y[31], (mag64(x) << FRAC_BITS) / mag64(y));
    endcase
  endfunction

  function automatic res_t eval_token(input tok_t t);
    res_t r;
    logic signed [31:0] x;
    logic signed [31:0] y;
    r.status = ST_OK;
    r.top_value = '0;
    r.stack_depth = '0;
    if (t.action == ACT_END) begin
      if (aborted_q) r.status = ST_ABORTED;
      else if (depth_q == 0) r.status = ST_EMPTY;
      else r.top_value = opnd_mem[depth_q-1];
      depth_q = 0;
      aborted_q = 1'b0;
      return r;
    end
    if (aborted_q) begin
      r.status = ST_ABORTED;
    end else if (t.action == ACT_PUSH) begin
      if (depth_q >= STACK_N) begin
        r.status = ST_FULL;
        aborted_q = 1'b1;
      end else begin
        opnd_mem[depth_q] = t.operand_value;
        depth_q++;
      end
    end else if (t.action >= ACT_ADD && t.action <= ACT_DIV) begin
      if (depth_q < 2) begin
        r.status = ST_FEW;
        aborted_q = 1'b1;
      end else begin
        x = opnd_mem[depth_q-2];
        y = opnd_mem[depth_q-1];
        if (t.action == ACT_DIV && y == 0) begin
          r.status = ST_DIVZERO;
          aborted_q = 1'b1;
        end else begin
          opnd_mem[depth_q-2] = apply_op(t.action, x, y);
          depth_q--;
        end
      end
    end else begin
      r.status = ST_UNKNOWN;
    end
    if (depth_q > 0) r.top_value = opnd_mem[depth_q-1];
    r.stack_depth = 7'(depth_q);
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic int idle_cycles(input int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 15);
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  function automatic logic [31:0] rand_value();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 9) << FRAC_BITS;
      2: v = $urandom_range(0, 32'h0003_FFFF);
      3: begin
        case ($urandom_range(0, 4))
          0: v = Q_MAX;
          1: v = Q_MIN;
          2: v = '0;
          3: v = 32'd1;
          default: v = Q_ONE;
        endcase
      end
      default: v = $urandom_range(0, 32'h00FF_FFFF);
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  function automatic logic [2:0] rand_op();
    return 3'(ACT_ADD) + 3'($urandom_range(0, 3));
  endfunction

  task automatic add_token(input logic [2:0] a, input logic [31:0] v);
    tok_t t;
    t.action = a;
    t.operand_value = v;
    pending_tokens.push_back(t);
  endtask

  task automatic gen_expression(input int max_pushes);
    int pushes_left;
    int d;
    pushes_left = $urandom_range(1, max_pushes);
    d = 0;
    while (pushes_left > 0 || d > 1) begin
      if (d < 2 || (pushes_left > 0 && $urandom_range(0, 1) == 1)) begin
        add_token(ACT_PUSH, rand_value());
        d++;
        pushes_left--;
      end else begin
        add_token(rand_op(), $urandom);
        d--;
      end
      if ($urandom_range(0, 30) == 0) begin
        add_token($urandom_range(0, 1) ? ACT_UNKNOWN : ACT_RESERVED, $urandom);
        n_random++;
      end
      n_random++;
    end
    add_token(ACT_END, $urandom);
    n_random++;
  endtask

  task automatic gen_fill();
    repeat (STACK_N + 1) add_token(ACT_PUSH, rand_value());
    add_token(rand_op(), $urandom);
    add_token(ACT_END, $urandom);
    n_random += STACK_N + 2;
  endtask

  task automatic gen_broken();
    int pushes;
    pushes = $urandom_range(0, 3);
    repeat (pushes) add_token(ACT_PUSH, rand_value());
    if (pushes > 0 && $urandom_range(0, 1) == 1) begin
      add_token(ACT_PUSH, '0);
      add_token(ACT_DIV, $urandom);
      pushes++;
    end else begin
      repeat (pushes) add_token(rand_op(), $urandom);
    end
    n_random += 2 * pushes + 1;
    repeat ($urandom_range(0, 2)) add_token(3'($urandom_range(0, 7)), rand_value());
    add_token(ACT_END, $urandom);
  endtask

  task automatic gen_noise();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) add_token(3'($urandom_range(0, 7)), rand_value());
    add_token(ACT_END, $urandom);
    n_random += n + 1;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on result beat %0d: %s got %h expected %h",
             results_checked, what, got, want);
    fail_count++;
  endtask

  // ---------------------------------------------------------------- driver
  always @(negedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (!tok_valid || tok_beat_done) begin
      if (tok_beat_done) begin
        tok_beats++;
        if (tok_beats % 40 == 0) tok_mode = $urandom_range(0, 2);
        tok_wait = idle_cycles(tok_mode);
      end
      if (tok_wait > 0 || pending_tokens.size() == 0) begin
        tok_valid <= 1'b0;
        if (tok_wait > 0) tok_wait--;
      end else begin
        tok_valid <= 1'b1;
        tok <= pending_tokens.pop_front();
      end
    end
  end

  always @(negedge clk) begin
    if (res_beat_done) begin
      res_beats++;
      if (res_beats % 40 == 0) res_mode = $urandom_range(0, 2);
      res_wait = idle_cycles(res_mode);
    end
    if (rst) begin
      res_stall <= 1'b0;
    end else if (res_hold) begin
      res_stall <= 1'b1;
    end else if (res_wait > 0) begin
      res_stall <= 1'b1;
      res_wait--;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // hold off the result side long enough for the token side to back up
  initial begin
    foreach (status_seen[i]) status_seen[i] = 0;
    for (int k = 1; k <= 2; k++) begin
      while (results_checked < 250 * k) @(negedge clk);
      res_hold <= 1'b1;
      repeat (300) @(negedge clk);
      res_hold <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin : sample_edge
    res_t want;
    tok_beat_done <= !rst && tok_valid && !tok_stall;
    res_beat_done <= !rst && res_valid && !res_stall;
    if (!rst && tok_valid && !tok_stall) expected_results.push_back(eval_token(tok));
    if (!rst && res_valid && !res_stall) begin
      results_checked++;
      status_seen[res.status]++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result beat", res.top_value, '0);
      end else begin
        want = expected_results.pop_front();
        if (res.status != want.status)
          report_mismatch("status", 32'(res.status), 32'(want.status));
        if (res.top_value != want.top_value)
          report_mismatch("top_value", res.top_value, want.top_value);
        if (res.stack_depth != want.stack_depth)
          report_mismatch("stack_depth", 32'(res.stack_depth), 32'(want.stack_depth));
      end
    end
  end

  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("tb_top NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    add_token(ACT_END, '0);
    add_token(ACT_ADD, '0);
    add_token(ACT_PUSH, Q_ONE);
    add_token(ACT_END, '0);
    add_token(ACT_UNKNOWN, Q_MAX);
    add_token(ACT_RESERVED, Q_MIN);
    add_token(ACT_PUSH, Q_MAX);
    add_token(ACT_PUSH, Q_MAX);
    add_token(ACT_ADD, '0);
    add_token(ACT_PUSH, Q_MIN);
    add_token(ACT_SUB, '0);
    add_token(ACT_END, '0);
    add_token(ACT_PUSH, Q_MIN);
    add_token(ACT_PUSH, -Q_ONE);
    add_token(ACT_MUL, '0);
    add_token(ACT_PUSH, 32'd1);
    add_token(ACT_DIV, '0);
    add_token(ACT_END, '0);
    add_token(ACT_PUSH, Q_MIN);
    add_token(ACT_PUSH, 32'd1);
    add_token(ACT_DIV, '0);
    add_token(ACT_PUSH, 32'h0003_0000);
    add_token(ACT_PUSH, 32'hFFFE_0000);
    add_token(ACT_DIV, '0);
    add_token(ACT_PUSH, '0);
    add_token(ACT_DIV, '0);
    add_token(ACT_PUSH, Q_ONE);
    add_token(ACT_END, '0);

    gen_fill();
    while (n_random < 750) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3, 4, 5: gen_expression(6);
        6:                gen_expression(40);
        7, 8:             gen_broken();
        9:                gen_noise();
        10:               gen_expression(2);
        default: begin
          if ($urandom_range(0, 4) == 0) gen_fill();
          else gen_expression(12);
        end
      endcase
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_tokens.size() != 0 || tok_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("missing result beats", 32'(expected_results.size()), '0);

    $display("run covered %0d token beats and %0d result beats in %0d cycles",
             tok_beats, results_checked, cycle_cnt);
    $display("statuses: ok %0d few %0d divzero %0d full %0d unknown %0d empty %0d aborted %0d",
             status_seen[ST_OK], status_seen[ST_FEW], status_seen[ST_DIVZERO],
             status_seen[ST_FULL], status_seen[ST_UNKNOWN], status_seen[ST_EMPTY],
             status_seen[ST_ABORTED]);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/pse_pkg.sv
hdl/pse_stack_ram.sv
hdl/pse_arith_unit.sv
hdl/postfix_stack_evaluator.sv
test/tb_top.sv
